[hw/rtl/lgalu_pkg.sv]
// Shared types, opcodes and helpers for the 8080 logical group ALU.
`timescale 1ns / 1ps
package lgalu_pkg;

  localparam int NUM_GP = 6;
  localparam int GP_AW  = $clog2(NUM_GP);

  localparam logic [7:0] OP_CMA = 8'h2F;
  localparam logic [7:0] OP_CMC = 8'h3F;
  localparam logic [7:0] OP_ANI = 8'hE6;
  localparam logic [7:0] OP_XRI = 8'hEE;
  localparam logic [7:0] OP_ORI = 8'hF6;
  localparam logic [2:0] GRP_LOGIC = 3'b101;

  localparam logic [2:0] SRC_M = 3'd6;
  localparam logic [2:0] SRC_A = 3'd7;

  localparam logic [2:0] SEL_H     = 3'd4;
  localparam logic [2:0] SEL_L     = 3'd5;
  localparam logic [2:0] SEL_A     = 3'd6;
  localparam logic [2:0] SEL_FLAGS = 3'd7;

  localparam int FLG_CY = 0;
  localparam int FLG_P  = 1;
  localparam int FLG_Z  = 2;
  localparam int FLG_S  = 3;

  typedef enum logic [1:0] {
    KIND_ANA = 2'd0,
    KIND_XRA = 2'd1,
    KIND_ORA = 2'd2,
    KIND_CMP = 2'd3
  } kind_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  opcode;
    logic [7:0]  data_byte;
    logic [2:0]  reg_select;
    logic [15:0] hl;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic        zero;
    logic        sign;
    logic        parity;
    logic        carry;
    logic [15:0] pc;
    logic [15:0] hl;
    logic        illegal;
  } result_t;

  function automatic logic [3:0] szp_of(input logic [7:0] v);
    logic [3:0] f;
    f         = '0;
    f[FLG_P]  = ~^v;
    f[FLG_Z]  = (v == 8'h00);
    f[FLG_S]  = v[7];
    return f;
  endfunction

endpackage

[hw/rtl/lgalu_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module lgalu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/lgalu_exec.sv]
// Execute stage: accumulator, flags and PC, and the logical group datapath.
`timescale 1ns / 1ps
module lgalu_exec import lgalu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  input  logic [7:0] operand,
  output result_t    res
);

  logic [7:0]  acc_r, acc_nxt;
  logic [3:0]  flg_r, flg_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic        illegal;
  logic [7:0]  src;
  logic [8:0]  diff;
  logic [7:0]  logic_res;
  kind_t       kind;

  always_comb begin
    case (item.opcode[2:0])
      SRC_M:   src = item.data_byte;
      SRC_A:   src = acc_r;
      default: src = operand;
    endcase
    kind = kind_t'(item.opcode[4:3]);
    diff = {1'b0, acc_r} - {1'b0, src};
    case (kind)
      KIND_ANA: logic_res = acc_r & src;
      KIND_XRA: logic_res = acc_r ^ src;
      KIND_ORA: logic_res = acc_r | src;
      default:  logic_res = acc_r;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    flg_nxt = flg_r;
    pc_nxt  = pc_r;
    illegal = 1'b0;
    if (item.action) begin
      if (item.reg_select == SEL_A) begin
        acc_nxt = item.data_byte;
      end else if (item.reg_select == SEL_FLAGS) begin
        flg_nxt = item.data_byte[3:0];
      end
    end else if (item.opcode[7:5] == GRP_LOGIC) begin
      if (kind == KIND_CMP) begin
        flg_nxt         = szp_of(diff[7:0]);
        flg_nxt[FLG_CY] = diff[8];
      end else begin
        acc_nxt = logic_res;
        flg_nxt = szp_of(logic_res);
      end
      pc_nxt = pc_r + 16'd1;
    end else if (item.opcode == OP_ANI || item.opcode == OP_XRI ||
                 item.opcode == OP_ORI) begin
      if (item.opcode == OP_ANI) begin
        acc_nxt = acc_r & item.data_byte;
      end else if (item.opcode == OP_XRI) begin
        acc_nxt = acc_r ^ item.data_byte;
      end else begin
        acc_nxt = acc_r | item.data_byte;
      end
      flg_nxt = szp_of(acc_nxt);
      pc_nxt  = pc_r + 16'd2;
    end else if (item.opcode == OP_CMA) begin
      acc_nxt = ~acc_r;
      pc_nxt  = pc_r + 16'd1;
    end else if (item.opcode == OP_CMC) begin
      flg_nxt[FLG_CY] = ~flg_r[FLG_CY];
      pc_nxt          = pc_r + 16'd1;
    end else begin
      illegal = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      flg_r <= '0;
      pc_r  <= '0;
    end else if (fire) begin
      acc_r <= acc_nxt;
      flg_r <= flg_nxt;
      pc_r  <= pc_nxt;
    end
  end

  always_comb begin
    res.acc     = acc_nxt;
    res.zero    = flg_nxt[FLG_Z];
    res.sign    = flg_nxt[FLG_S];
    res.parity  = flg_nxt[FLG_P];
    res.carry   = flg_nxt[FLG_CY];
    res.pc      = pc_nxt;
    res.hl      = item.hl;
    res.illegal = illegal;
  end

  a_illegal_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && illegal |=> $stable(pc_r) && $stable(acc_r) && $stable(flg_r))
    else $error("illegal opcode changed architectural state");

  a_cma_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.action && item.opcode == OP_CMA |=> $stable(flg_r))
    else $error("CMA altered flags");

endmodule

[hw/rtl/i8080_logic_group_alu.sv]
// Top level of the 8080 logical group ALU: handshake, register file and output stage.
// After acceptance a transaction is held in the execute-stage register, then its result in the output register.
// Throughput: one transaction per cycle while the output is not stalled; the register file read lines up with execute.
// B..L live in a RAM with registered read; loads write it at acceptance, reads are reissued
// while the execute stage stalls, so no forwarding is needed.
// Reset (synchronous, active low) zeroes A, flags, PC and per-entry valid bits; no sweep.
`timescale 1ns / 1ps
module i8080_logic_group_alu import lgalu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [2:0]  in_reg_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_acc_out,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_parity_flag,
  output logic        out_carry_flag,
  output logic [15:0] out_pc_out,
  output logic [15:0] out_hl_address,
  output logic        out_illegal
);

  logic              in_fire, s1_fire;
  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r, in_item;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, ex_res;
  logic [7:0]        h_r, l_r, h_nxt, l_nxt;
  logic [NUM_GP-1:0] gp_vld_r;
  logic              rd_vld_r;
  logic              gp_we;
  logic [2:0]        rd_sel;
  logic [GP_AW-1:0]  rd_addr;
  logic [7:0]        ram_rdata, operand;

  assign in_fire  = in_valid & in_ready;
  assign s1_fire  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_fire;

  assign gp_we   = in_fire & in_action & (in_reg_select < 3'(NUM_GP));
  assign rd_sel  = in_ready ? in_opcode[2:0] : s1_item_r.opcode[2:0];
  assign rd_addr = (rd_sel < 3'(NUM_GP)) ? GP_AW'(rd_sel) : '0;
  assign operand = rd_vld_r ? ram_rdata : 8'h00;

  lgalu_ram #(
    .WIDTH (8),
    .DEPTH (NUM_GP)
  ) u_gp_ram (
    .clk   (clk),
    .we    (gp_we),
    .waddr (GP_AW'(in_reg_select)),
    .wdata (in_data_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    h_nxt = h_r;
    l_nxt = l_r;
    if (in_action && in_reg_select == SEL_H) begin
      h_nxt = in_data_byte;
    end
    if (in_action && in_reg_select == SEL_L) begin
      l_nxt = in_data_byte;
    end
    in_item.action     = in_action;
    in_item.opcode     = in_opcode;
    in_item.data_byte  = in_data_byte;
    in_item.reg_select = in_reg_select;
    in_item.hl         = {h_nxt, l_nxt};
  end

  assign s1_valid_nxt  = in_fire | (s1_valid_r & ~s1_fire);
  assign out_valid_nxt = s1_fire | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      h_r         <= '0;
      l_r         <= '0;
      gp_vld_r    <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= gp_vld_r[rd_addr];
      if (in_fire) begin
        h_r <= h_nxt;
        l_r <= l_nxt;
      end
      if (gp_we) begin
        gp_vld_r[GP_AW'(in_reg_select)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_res_r <= ex_res;
    end
  end

  lgalu_exec u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .item    (s1_item_r),
    .operand (operand),
    .res     (ex_res)
  );

  assign out_valid       = out_valid_r;
  assign out_acc_out     = out_res_r.acc;
  assign out_zero_flag   = out_res_r.zero;
  assign out_sign_flag   = out_res_r.sign;
  assign out_parity_flag = out_res_r.parity;
  assign out_carry_flag  = out_res_r.carry;
  assign out_pc_out      = out_res_r.pc;
  assign out_hl_address  = out_res_r.hl;
  assign out_illegal     = out_res_r.illegal;

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_item_r))
    else $error("execute stage lost or changed a stalled transaction");

  a_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |-> !gp_we)
    else $error("register file written while execute stage stalled");

  a_hl_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_item_r.hl == {h_r, l_r})
    else $error("HL shadow out of step with accepted transaction");

endmodule
